// ----- src/esc_pkg.sv -----
package esc_pkg;

    // Request opcodes
    localparam logic [1:0] OPC_TEMP  = 2'd0;
    localparam logic [1:0] OPC_PRESS = 2'd1;
    localparam logic [1:0] OPC_HUMID = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_TEMP       = 3'd0;
    localparam logic [2:0] CFG_PRESS_LOW  = 3'd1;
    localparam logic [2:0] CFG_PRESS_HIGH = 3'd2;
    localparam logic [2:0] CFG_MIXED      = 3'd3;
    localparam logic [2:0] CFG_HUMID      = 3'd4;

    // Shared unit operations
    localparam logic [2:0] ALU_ADD   = 3'd0;
    localparam logic [2:0] ALU_SUB   = 3'd1;
    localparam logic [2:0] ALU_MUL   = 3'd2;
    localparam logic [2:0] ALU_SHL   = 3'd3;
    localparam logic [2:0] ALU_ASR   = 3'd4;
    localparam logic [2:0] ALU_DIV   = 3'd5;
    localparam logic [2:0] ALU_CLAMP = 3'd6;

    typedef logic [5:0] src_t;

    // Operand sources
    localparam src_t SRC_R0     = 6'd0;
    localparam src_t SRC_R1     = 6'd1;
    localparam src_t SRC_R2     = 6'd2;
    localparam src_t SRC_R3     = 6'd3;
    localparam src_t SRC_RAW    = 6'd4;
    localparam src_t SRC_RAWH   = 6'd5;
    localparam src_t SRC_FINE   = 6'd6;
    localparam src_t SRC_T1     = 6'd7;
    localparam src_t SRC_T2     = 6'd8;
    localparam src_t SRC_T3     = 6'd9;
    localparam src_t SRC_P1     = 6'd10;
    localparam src_t SRC_P2     = 6'd11;
    localparam src_t SRC_P3     = 6'd12;
    localparam src_t SRC_P4     = 6'd13;
    localparam src_t SRC_P5     = 6'd14;
    localparam src_t SRC_P6     = 6'd15;
    localparam src_t SRC_P7     = 6'd16;
    localparam src_t SRC_P8     = 6'd17;
    localparam src_t SRC_P9     = 6'd18;
    localparam src_t SRC_H1     = 6'd19;
    localparam src_t SRC_H2     = 6'd20;
    localparam src_t SRC_H3     = 6'd21;
    localparam src_t SRC_H4     = 6'd22;
    localparam src_t SRC_H5     = 6'd23;
    localparam src_t SRC_H6     = 6'd24;
    localparam src_t SRC_C5     = 6'd25;
    localparam src_t SRC_C128   = 6'd26;
    localparam src_t SRC_C128K  = 6'd27;
    localparam src_t SRC_C3125  = 6'd28;
    localparam src_t SRC_C1M    = 6'd29;
    localparam src_t SRC_C2P47  = 6'd30;
    localparam src_t SRC_C76800 = 6'd31;
    localparam src_t SRC_C16384 = 6'd32;
    localparam src_t SRC_C32768 = 6'd33;
    localparam src_t SRC_C2M    = 6'd34;
    localparam src_t SRC_C8192  = 6'd35;
    localparam src_t SRC_ZERO   = 6'd36;

    // Instruction flags: {wrap32, fine write, zero check, last}
    localparam logic [3:0] F_NONE = 4'b0000;
    localparam logic [3:0] F_W    = 4'b1000;
    localparam logic [3:0] F_WF   = 4'b1100;
    localparam logic [3:0] F_Z    = 4'b0010;
    localparam logic [3:0] F_L    = 4'b0001;
    localparam logic [3:0] F_WL   = 4'b1001;

    // Program entry points
    localparam logic [6:0] UPC_TEMP  = 7'd0;
    localparam logic [6:0] UPC_PRESS = 7'd15;
    localparam logic [6:0] UPC_HUMID = 7'd47;

    localparam logic [63:0] HUMID_CAP = 64'd419430400;

    typedef struct packed {
        logic [2:0] op;
        logic [1:0] dst;
        src_t       a;
        src_t       b;
        logic [5:0] sh;
        logic       w32;
        logic       fine;
        logic       zchk;
        logic       last;
    } uinst_t;

    typedef struct packed {
        logic       req;
        logic [2:0] op;
        logic [5:0] sh;
    } alu_cmd_t;

    function automatic uinst_t ui(logic [2:0] op, logic [1:0] dst, src_t a, src_t b,
                                  logic [5:0] sh, logic [3:0] fl);
        uinst_t u;
        u.op   = op;
        u.dst  = dst;
        u.a    = a;
        u.b    = b;
        u.sh   = sh;
        u.w32  = fl[3];
        u.fine = fl[2];
        u.zchk = fl[1];
        u.last = fl[0];
        return u;
    endfunction

    // Compensation programs for the shared unit.
    function automatic uinst_t ucode(logic [6:0] addr);
        uinst_t u;
        unique case (addr)
            // Temperature
            7'd0:  u = ui(ALU_ASR, 2'd0, SRC_RAW,  SRC_ZERO, 6'd3,  F_W);
            7'd1:  u = ui(ALU_SHL, 2'd1, SRC_T1,   SRC_ZERO, 6'd1,  F_W);
            7'd2:  u = ui(ALU_SUB, 2'd0, SRC_R0,   SRC_R1,   6'd0,  F_W);
            7'd3:  u = ui(ALU_MUL, 2'd0, SRC_R0,   SRC_T2,   6'd0,  F_W);
            7'd4:  u = ui(ALU_ASR, 2'd0, SRC_R0,   SRC_ZERO, 6'd11, F_W);
            7'd5:  u = ui(ALU_ASR, 2'd1, SRC_RAW,  SRC_ZERO, 6'd4,  F_W);
            7'd6:  u = ui(ALU_SUB, 2'd1, SRC_R1,   SRC_T1,   6'd0,  F_W);
            7'd7:  u = ui(ALU_MUL, 2'd1, SRC_R1,   SRC_R1,   6'd0,  F_W);
            7'd8:  u = ui(ALU_ASR, 2'd1, SRC_R1,   SRC_ZERO, 6'd12, F_W);
            7'd9:  u = ui(ALU_MUL, 2'd1, SRC_R1,   SRC_T3,   6'd0,  F_W);
            7'd10: u = ui(ALU_ASR, 2'd1, SRC_R1,   SRC_ZERO, 6'd14, F_W);
            7'd11: u = ui(ALU_ADD, 2'd0, SRC_R0,   SRC_R1,   6'd0,  F_WF);
            7'd12: u = ui(ALU_MUL, 2'd0, SRC_R0,   SRC_C5,   6'd0,  F_W);
            7'd13: u = ui(ALU_ADD, 2'd0, SRC_R0,   SRC_C128, 6'd0,  F_W);
            7'd14: u = ui(ALU_ASR, 2'd0, SRC_R0,   SRC_ZERO, 6'd8,  F_WL);
            // Pressure
            7'd15: u = ui(ALU_SUB, 2'd0, SRC_FINE, SRC_C128K, 6'd0, F_NONE);
            7'd16: u = ui(ALU_MUL, 2'd1, SRC_R0,   SRC_R0,   6'd0,  F_NONE);
            7'd17: u = ui(ALU_MUL, 2'd2, SRC_R1,   SRC_P6,   6'd0,  F_NONE);
            7'd18: u = ui(ALU_MUL, 2'd3, SRC_R0,   SRC_P5,   6'd0,  F_NONE);
            7'd19: u = ui(ALU_SHL, 2'd3, SRC_R3,   SRC_ZERO, 6'd17, F_NONE);
            7'd20: u = ui(ALU_ADD, 2'd2, SRC_R2,   SRC_R3,   6'd0,  F_NONE);
            7'd21: u = ui(ALU_SHL, 2'd3, SRC_P4,   SRC_ZERO, 6'd35, F_NONE);
            7'd22: u = ui(ALU_ADD, 2'd2, SRC_R2,   SRC_R3,   6'd0,  F_NONE);
            7'd23: u = ui(ALU_MUL, 2'd1, SRC_R1,   SRC_P3,   6'd0,  F_NONE);
            7'd24: u = ui(ALU_ASR, 2'd1, SRC_R1,   SRC_ZERO, 6'd8,  F_NONE);
            7'd25: u = ui(ALU_MUL, 2'd3, SRC_R0,   SRC_P2,   6'd0,  F_NONE);
            7'd26: u = ui(ALU_SHL, 2'd3, SRC_R3,   SRC_ZERO, 6'd12, F_NONE);
            7'd27: u = ui(ALU_ADD, 2'd0, SRC_R1,   SRC_R3,   6'd0,  F_NONE);
            7'd28: u = ui(ALU_ADD, 2'd0, SRC_R0,   SRC_C2P47, 6'd0, F_NONE);
            7'd29: u = ui(ALU_MUL, 2'd0, SRC_R0,   SRC_P1,   6'd0,  F_NONE);
            7'd30: u = ui(ALU_ASR, 2'd0, SRC_R0,   SRC_ZERO, 6'd33, F_Z);
            7'd31: u = ui(ALU_SUB, 2'd1, SRC_C1M,  SRC_RAW,  6'd0,  F_NONE);
            7'd32: u = ui(ALU_SHL, 2'd1, SRC_R1,   SRC_ZERO, 6'd31, F_NONE);
            7'd33: u = ui(ALU_SUB, 2'd1, SRC_R1,   SRC_R2,   6'd0,  F_NONE);
            7'd34: u = ui(ALU_MUL, 2'd1, SRC_R1,   SRC_C3125, 6'd0, F_NONE);
            7'd35: u = ui(ALU_DIV, 2'd1, SRC_R1,   SRC_R0,   6'd0,  F_NONE);
            7'd36: u = ui(ALU_ASR, 2'd2, SRC_R1,   SRC_ZERO, 6'd13, F_NONE);
            7'd37: u = ui(ALU_MUL, 2'd3, SRC_R2,   SRC_R2,   6'd0,  F_NONE);
            7'd38: u = ui(ALU_MUL, 2'd3, SRC_R3,   SRC_P9,   6'd0,  F_NONE);
            7'd39: u = ui(ALU_ASR, 2'd3, SRC_R3,   SRC_ZERO, 6'd25, F_NONE);
            7'd40: u = ui(ALU_MUL, 2'd2, SRC_R1,   SRC_P8,   6'd0,  F_NONE);
            7'd41: u = ui(ALU_ASR, 2'd2, SRC_R2,   SRC_ZERO, 6'd19, F_NONE);
            7'd42: u = ui(ALU_ADD, 2'd1, SRC_R1,   SRC_R3,   6'd0,  F_NONE);
            7'd43: u = ui(ALU_ADD, 2'd1, SRC_R1,   SRC_R2,   6'd0,  F_NONE);
            7'd44: u = ui(ALU_ASR, 2'd1, SRC_R1,   SRC_ZERO, 6'd8,  F_NONE);
            7'd45: u = ui(ALU_SHL, 2'd2, SRC_P7,   SRC_ZERO, 6'd4,  F_NONE);
            7'd46: u = ui(ALU_ADD, 2'd1, SRC_R1,   SRC_R2,   6'd0,  F_L);
            // Humidity
            7'd47: u = ui(ALU_SUB, 2'd0, SRC_FINE, SRC_C76800, 6'd0, F_W);
            7'd48: u = ui(ALU_SHL, 2'd1, SRC_RAWH, SRC_ZERO, 6'd14, F_W);
            7'd49: u = ui(ALU_SHL, 2'd2, SRC_H4,   SRC_ZERO, 6'd20, F_W);
            7'd50: u = ui(ALU_SUB, 2'd1, SRC_R1,   SRC_R2,   6'd0,  F_W);
            7'd51: u = ui(ALU_MUL, 2'd2, SRC_H5,   SRC_R0,   6'd0,  F_W);
            7'd52: u = ui(ALU_SUB, 2'd1, SRC_R1,   SRC_R2,   6'd0,  F_W);
            7'd53: u = ui(ALU_ADD, 2'd1, SRC_R1,   SRC_C16384, 6'd0, F_W);
            7'd54: u = ui(ALU_ASR, 2'd1, SRC_R1,   SRC_ZERO, 6'd15, F_W);
            7'd55: u = ui(ALU_MUL, 2'd2, SRC_R0,   SRC_H6,   6'd0,  F_W);
            7'd56: u = ui(ALU_ASR, 2'd2, SRC_R2,   SRC_ZERO, 6'd10, F_W);
            7'd57: u = ui(ALU_MUL, 2'd3, SRC_R0,   SRC_H3,   6'd0,  F_W);
            7'd58: u = ui(ALU_ASR, 2'd3, SRC_R3,   SRC_ZERO, 6'd11, F_W);
            7'd59: u = ui(ALU_ADD, 2'd3, SRC_R3,   SRC_C32768, 6'd0, F_W);
            7'd60: u = ui(ALU_MUL, 2'd2, SRC_R2,   SRC_R3,   6'd0,  F_W);
            7'd61: u = ui(ALU_ASR, 2'd2, SRC_R2,   SRC_ZERO, 6'd10, F_W);
            7'd62: u = ui(ALU_ADD, 2'd2, SRC_R2,   SRC_C2M,  6'd0,  F_W);
            7'd63: u = ui(ALU_MUL, 2'd2, SRC_R2,   SRC_H2,   6'd0,  F_W);
            7'd64: u = ui(ALU_ADD, 2'd2, SRC_R2,   SRC_C8192, 6'd0, F_W);
            7'd65: u = ui(ALU_ASR, 2'd2, SRC_R2,   SRC_ZERO, 6'd14, F_W);
            7'd66: u = ui(ALU_MUL, 2'd1, SRC_R1,   SRC_R2,   6'd0,  F_W);
            7'd67: u = ui(ALU_ASR, 2'd2, SRC_R1,   SRC_ZERO, 6'd15, F_W);
            7'd68: u = ui(ALU_MUL, 2'd2, SRC_R2,   SRC_R2,   6'd0,  F_W);
            7'd69: u = ui(ALU_ASR, 2'd2, SRC_R2,   SRC_ZERO, 6'd7,  F_W);
            7'd70: u = ui(ALU_MUL, 2'd2, SRC_R2,   SRC_H1,   6'd0,  F_W);
            7'd71: u = ui(ALU_ASR, 2'd2, SRC_R2,   SRC_ZERO, 6'd4,  F_W);
            7'd72: u = ui(ALU_SUB, 2'd1, SRC_R1,   SRC_R2,   6'd0,  F_W);
            7'd73: u = ui(ALU_CLAMP, 2'd1, SRC_R1, SRC_ZERO, 6'd0,  F_W);
            7'd74: u = ui(ALU_ASR, 2'd1, SRC_R1,   SRC_ZERO, 6'd12, F_WL);
            default: u = ui(ALU_ADD, 2'd0, SRC_ZERO, SRC_ZERO, 6'd0, F_L);
        endcase
        return u;
    endfunction

endpackage

// ----- src/esc_alu.sv -----
module esc_alu (
    input  logic              aclk,
    input  logic              aresetn,
    input  esc_pkg::alu_cmd_t cmd,
    input  logic [63:0]       opa,
    input  logic [63:0]       opb,
    output logic              done,
    output logic [63:0]       result
);

    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_MUL1 = 3'd1;
    localparam logic [2:0] A_MUL2 = 3'd2;
    localparam logic [2:0] A_DIV  = 3'd3;
    localparam logic [2:0] A_DFIN = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] dvs_reg, dvs_next;
    logic        neg_reg, neg_next;
    logic [5:0]  cnt_reg, cnt_next;

    logic [31:0] mul_x, mul_y;
    logic [63:0] prod;
    logic [63:0] simple;
    logic [64:0] trial;
    logic [64:0] diff;

    // One 32x32 multiplier, three passes build the low 64 bits of a product.
    always_comb begin
        unique case (state_reg)
            A_MUL1: begin
                mul_x = opa[31:0];
                mul_y = opb[63:32];
            end
            A_MUL2: begin
                mul_x = opa[63:32];
                mul_y = opb[31:0];
            end
            default: begin
                mul_x = opa[31:0];
                mul_y = opb[31:0];
            end
        endcase
    end

    assign prod = 64'(mul_x) * 64'(mul_y);

    // Operations that finish in the same cycle as the request.
    always_comb begin
        case (cmd.op)
            esc_pkg::ALU_ADD:   simple = opa + opb;
            esc_pkg::ALU_SUB:   simple = opa - opb;
            esc_pkg::ALU_SHL:   simple = opa << cmd.sh;
            esc_pkg::ALU_ASR:   simple = 64'($signed(opa) >>> cmd.sh);
            esc_pkg::ALU_CLAMP: begin
                if (opa[63]) begin
                    simple = '0;
                end else if (opa > esc_pkg::HUMID_CAP) begin
                    simple = esc_pkg::HUMID_CAP;
                end else begin
                    simple = opa;
                end
            end
            default:            simple = opa;
        endcase
    end

    // Restoring divider step on magnitudes.
    assign trial = {rem_reg, quo_reg[63]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        state_next = state_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        dvs_next   = dvs_reg;
        neg_next   = neg_reg;
        cnt_next   = cnt_reg;
        done       = 1'b0;
        result     = simple;
        unique case (state_reg)
            A_IDLE: begin
                if (cmd.req) begin
                    if (cmd.op == esc_pkg::ALU_MUL) begin
                        acc_next   = prod;
                        state_next = A_MUL1;
                    end else if (cmd.op == esc_pkg::ALU_DIV) begin
                        quo_next   = opa[63] ? (64'd0 - opa) : opa;
                        dvs_next   = opb[63] ? (64'd0 - opb) : opb;
                        neg_next   = opa[63] ^ opb[63];
                        rem_next   = '0;
                        cnt_next   = '0;
                        state_next = A_DIV;
                    end else begin
                        done = 1'b1;
                    end
                end
            end
            A_MUL1: begin
                acc_next   = acc_reg + {prod[31:0], 32'd0};
                state_next = A_MUL2;
            end
            A_MUL2: begin
                result     = acc_reg + {prod[31:0], 32'd0};
                done       = 1'b1;
                state_next = A_IDLE;
            end
            A_DIV: begin
                if (!diff[64]) begin
                    rem_next = diff[63:0];
                    quo_next = {quo_reg[62:0], 1'b1};
                end else begin
                    rem_next = trial[63:0];
                    quo_next = {quo_reg[62:0], 1'b0};
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    state_next = A_DFIN;
                end
            end
            A_DFIN: begin
                result     = neg_reg ? (64'd0 - quo_reg) : quo_reg;
                done       = 1'b1;
                state_next = A_IDLE;
            end
            default: state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
        end else begin
            state_reg <= state_next;
        end
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
    end

endmodule

// ----- src/env_sensor_compensation.sv -----
// Channel   | Ports                                   | Direction
// request   | s_valid s_ready s_opcode s_raw_reading  | in
// result    | m_valid m_ready m_reading m_divide_guard | out
// config    | cfg_wr_en cfg_index cfg_wdata           | in
//
// One request at a time runs a short program on a shared add/shift/multiply/divide unit.
// Pressure runs longest, as the 64-step divider dominates, but it ends before the divide
// when the divisor is zero; unknown opcodes run no program. A multiply reuses one 32x32 multiplier.
// Reset (aresetn low, synchronous) clears coefficients, fine temperature and control.
// A new request is taken while a finished result waits; the next result waits for m_ready.
module env_sensor_compensation (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_opcode,
    input  logic [19:0] s_raw_reading,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_reading,
    output logic        m_divide_guard,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_wdata
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]  state_reg, state_next;
    logic [6:0]  upc_reg, upc_next;
    logic [19:0] raw_reg, raw_next;
    logic [31:0] fine_reg, fine_next;
    logic [31:0] res_reg, res_next;
    logic        guard_reg, guard_next;
    logic [63:0] r0_reg, r1_reg, r2_reg, r3_reg;
    logic [47:0] tc_reg;
    logic [63:0] pl_reg, ph_reg;
    logic [47:0] mx_reg;
    logic [39:0] hc_reg;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_reading_reg;
    logic        m_guard_reg;
    logic        load_out;

    esc_pkg::uinst_t  uinst;
    esc_pkg::alu_cmd_t cmd;
    logic [63:0] opa, opb, alu_res, wval;
    logic        alu_done, wr_en;

    function automatic logic [63:0] sx16(logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    // Operand source selection.
    function automatic logic [63:0] pick(esc_pkg::src_t s);
        logic [63:0] v;
        case (s)
            esc_pkg::SRC_R0:     v = r0_reg;
            esc_pkg::SRC_R1:     v = r1_reg;
            esc_pkg::SRC_R2:     v = r2_reg;
            esc_pkg::SRC_R3:     v = r3_reg;
            esc_pkg::SRC_RAW:    v = 64'(raw_reg);
            esc_pkg::SRC_RAWH:   v = 64'(raw_reg[15:0]);
            esc_pkg::SRC_FINE:   v = {{32{fine_reg[31]}}, fine_reg};
            esc_pkg::SRC_T1:     v = 64'(tc_reg[15:0]);
            esc_pkg::SRC_T2:     v = sx16(tc_reg[31:16]);
            esc_pkg::SRC_T3:     v = sx16(tc_reg[47:32]);
            esc_pkg::SRC_P1:     v = 64'(pl_reg[15:0]);
            esc_pkg::SRC_P2:     v = sx16(pl_reg[31:16]);
            esc_pkg::SRC_P3:     v = sx16(pl_reg[47:32]);
            esc_pkg::SRC_P4:     v = sx16(pl_reg[63:48]);
            esc_pkg::SRC_P5:     v = sx16(ph_reg[15:0]);
            esc_pkg::SRC_P6:     v = sx16(ph_reg[31:16]);
            esc_pkg::SRC_P7:     v = sx16(ph_reg[47:32]);
            esc_pkg::SRC_P8:     v = sx16(ph_reg[63:48]);
            esc_pkg::SRC_P9:     v = sx16(mx_reg[15:0]);
            esc_pkg::SRC_H1:     v = 64'(mx_reg[23:16]);
            esc_pkg::SRC_H2:     v = sx16(mx_reg[39:24]);
            esc_pkg::SRC_H3:     v = 64'(mx_reg[47:40]);
            esc_pkg::SRC_H4:     v = sx16(hc_reg[15:0]);
            esc_pkg::SRC_H5:     v = sx16(hc_reg[31:16]);
            esc_pkg::SRC_H6:     v = {{56{hc_reg[39]}}, hc_reg[39:32]};
            esc_pkg::SRC_C5:     v = 64'd5;
            esc_pkg::SRC_C128:   v = 64'd128;
            esc_pkg::SRC_C128K:  v = 64'd128000;
            esc_pkg::SRC_C3125:  v = 64'd3125;
            esc_pkg::SRC_C1M:    v = 64'd1048576;
            esc_pkg::SRC_C2P47:  v = 64'd1 << 47;
            esc_pkg::SRC_C76800: v = 64'd76800;
            esc_pkg::SRC_C16384: v = 64'd16384;
            esc_pkg::SRC_C32768: v = 64'd32768;
            esc_pkg::SRC_C2M:    v = 64'd2097152;
            esc_pkg::SRC_C8192:  v = 64'd8192;
            default:             v = '0;
        endcase
        return v;
    endfunction

    assign uinst   = esc_pkg::ucode(upc_reg);
    assign opa     = pick(uinst.a);
    assign opb     = pick(uinst.b);
    assign cmd.req = (state_reg == S_RUN);
    assign cmd.op  = uinst.op;
    assign cmd.sh  = uinst.sh;

    esc_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .opa     (opa),
        .opb     (opb),
        .done    (alu_done),
        .result  (alu_res)
    );

    // 32-bit steps wrap and sign-extend before writeback.
    assign wval  = uinst.w32 ? {{32{alu_res[31]}}, alu_res[31:0]} : alu_res;
    assign wr_en = (state_reg == S_RUN) && alu_done;

    assign s_ready  = (state_reg == S_IDLE);
    assign load_out = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    // Sequencer.
    always_comb begin
        state_next = state_reg;
        upc_next   = upc_reg;
        raw_next   = raw_reg;
        fine_next  = fine_reg;
        res_next   = res_reg;
        guard_next = guard_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    raw_next   = s_raw_reading;
                    guard_next = 1'b0;
                    res_next   = '0;
                    case (s_opcode)
                        esc_pkg::OPC_TEMP: begin
                            upc_next   = esc_pkg::UPC_TEMP;
                            state_next = S_RUN;
                        end
                        esc_pkg::OPC_PRESS: begin
                            upc_next   = esc_pkg::UPC_PRESS;
                            state_next = S_RUN;
                        end
                        esc_pkg::OPC_HUMID: begin
                            upc_next   = esc_pkg::UPC_HUMID;
                            state_next = S_RUN;
                        end
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_RUN: begin
                if (alu_done) begin
                    if (uinst.fine) begin
                        fine_next = wval[31:0];
                    end
                    if (uinst.zchk && (wval == 64'd0)) begin
                        res_next   = '0;
                        guard_next = 1'b1;
                        state_next = S_DONE;
                    end else if (uinst.last) begin
                        res_next   = wval[31:0];
                        state_next = S_DONE;
                    end else begin
                        upc_next = upc_reg + 7'd1;
                    end
                end
            end
            S_DONE: begin
                if (load_out) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign m_valid_next = load_out || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            fine_reg    <= '0;
            m_valid_reg <= 1'b0;
            tc_reg      <= '0;
            pl_reg      <= '0;
            ph_reg      <= '0;
            mx_reg      <= '0;
            hc_reg      <= '0;
        end else begin
            state_reg   <= state_next;
            fine_reg    <= fine_next;
            m_valid_reg <= m_valid_next;
            // Coefficient writes.
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    esc_pkg::CFG_TEMP:       tc_reg <= cfg_wdata[47:0];
                    esc_pkg::CFG_PRESS_LOW:  pl_reg <= cfg_wdata;
                    esc_pkg::CFG_PRESS_HIGH: ph_reg <= cfg_wdata;
                    esc_pkg::CFG_MIXED:      mx_reg <= cfg_wdata[47:0];
                    esc_pkg::CFG_HUMID:      hc_reg <= cfg_wdata[39:0];
                    default: ;
                endcase
            end
        end
        upc_reg   <= upc_next;
        raw_reg   <= raw_next;
        res_reg   <= res_next;
        guard_reg <= guard_next;
        // Working registers.
        if (wr_en) begin
            case (uinst.dst)
                2'd0:    r0_reg <= wval;
                2'd1:    r1_reg <= wval;
                2'd2:    r2_reg <= wval;
                default: r3_reg <= wval;
            endcase
        end
        if (load_out) begin
            m_reading_reg <= res_reg;
            m_guard_reg   <= guard_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_reading      = m_reading_reg;
    assign m_divide_guard = m_guard_reg;

`ifndef SYNTHESIS
    // The shared unit only finishes work issued by a running program.
    a_alu_in_run: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_done |-> (state_reg == S_RUN))
        else $error("shared unit finished outside a program");

    // A guarded pressure result always reads zero.
    a_guard_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_divide_guard) |-> (m_reading == 32'd0))
        else $error("guarded result is not zero");

    // After a request is taken the block is not ready in the next cycle.
    a_busy_after: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request taken while busy");
`endif

endmodule

// ----- verif/env_sensor_compensation_tb.sv -----
`timescale 1ns / 100ps

module env_sensor_compensation_tb;

    localparam logic [1:0] OPC_UNUSED = 2'd3;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_opcode;
    logic [19:0] s_raw_reading;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_reading;
    logic        m_divide_guard;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_wdata;

    env_sensor_compensation DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_raw_reading(s_raw_reading),
        .m_valid(m_valid), .m_ready(m_ready), .m_reading(m_reading),
        .m_divide_guard(m_divide_guard),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    typedef struct packed {
        logic [31:0] reading;
        logic        guard;
    } sample_t;

    // Shadow calibration and fine temperature.
    logic [47:0] cal_temp;
    logic [63:0] cal_press_lo;
    logic [63:0] cal_press_hi;
    logic [47:0] cal_mixed;
    logic [39:0] cal_humid;
    logic [31:0] fine_temp;

    sample_t     pending_samples[$];
    int          error_count;
    int          sample_count;
    int          request_count;
    int          guard_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_cycles;

    // Clock.
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Timeout.
    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic signed [63:0] sx16(logic [15:0] v);
        return {{48{v[15]}}, v};
    endfunction

    function automatic logic signed [63:0] sdiv_trunc(logic signed [63:0] n,
                                                      logic signed [63:0] d);
        logic [63:0] an;
        logic [63:0] ad;
        logic [63:0] q;
        an = n[63] ? -n : n;
        ad = d[63] ? -d : d;
        q  = an / ad;
        return (n[63] != d[63]) ? -q : q;
    endfunction

    // Temperature: hundredths of a degree, updates the fine temperature.
    function automatic logic [31:0] compensate_temp(logic [19:0] raw);
        logic [31:0] t1;
        logic signed [31:0] t2, t3, d1, d2, v1, v2, f, r;
        t1 = {16'd0, cal_temp[15:0]};
        t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
        t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
        d1 = {15'd0, raw[19:3]} - (t1 << 1);
        v1 = (d1 * t2) >>> 11;
        d2 = {16'd0, raw[19:4]} - t1;
        v2 = (((d2 * d2) >>> 12) * t3) >>> 14;
        f  = v1 + v2;
        fine_temp = f;
        r = (f * 32'sd5 + 32'sd128) >>> 8;
        return r;
    endfunction

    // Pressure: Q24.8 Pa with 64-bit intermediates.
    function automatic sample_t compensate_press(logic [19:0] raw);
        logic signed [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
        logic signed [63:0] v1, v2, p, a, b;
        sample_t s;
        p1 = {48'd0, cal_press_lo[15:0]};
        p2 = sx16(cal_press_lo[31:16]);
        p3 = sx16(cal_press_lo[47:32]);
        p4 = sx16(cal_press_lo[63:48]);
        p5 = sx16(cal_press_hi[15:0]);
        p6 = sx16(cal_press_hi[31:16]);
        p7 = sx16(cal_press_hi[47:32]);
        p8 = sx16(cal_press_hi[63:48]);
        p9 = sx16(cal_mixed[15:0]);
        v1 = {{32{fine_temp[31]}}, fine_temp} - 64'sd128000;
        v2 = v1 * v1 * p6;
        v2 = v2 + ((v1 * p5) <<< 17);
        v2 = v2 + (p4 <<< 35);
        v1 = ((v1 * v1 * p3) >>> 8) + ((v1 * p2) <<< 12);
        v1 = (((64'sd1 <<< 47) + v1) * p1) >>> 33;
        s.reading = '0;
        s.guard   = 1'b0;
        if (v1 == 0) begin
            s.guard = 1'b1;
            return s;
        end
        p = 64'sd1048576 - {44'd0, raw};
        p = sdiv_trunc(((p <<< 31) - v2) * 64'sd3125, v1);
        a = (p9 * (p >>> 13) * (p >>> 13)) >>> 25;
        b = (p8 * p) >>> 19;
        p = ((p + a + b) >>> 8) + (p7 <<< 4);
        s.reading = p[31:0];
        return s;
    endfunction

    // Humidity: Q22.10 %RH with the clamp before the last shift.
    function automatic logic [31:0] compensate_humid(logic [19:0] raw);
        logic signed [31:0] h1, h2, h3, h4, h5, h6, x, lead, scale, sq;
        h1 = {24'd0, cal_mixed[23:16]};
        h2 = {{16{cal_mixed[39]}}, cal_mixed[39:24]};
        h3 = {24'd0, cal_mixed[47:40]};
        h4 = {{16{cal_humid[15]}}, cal_humid[15:0]};
        h5 = {{16{cal_humid[31]}}, cal_humid[31:16]};
        h6 = {{24{cal_humid[39]}}, cal_humid[39:32]};
        x = fine_temp - 32'sd76800;
        lead = ({16'd0, raw[15:0]} << 14) - (h4 << 20) - h5 * x;
        lead = (lead + 32'sd16384) >>> 15;
        scale = ((x * h6) >>> 10) * (((x * h3) >>> 11) + 32'sd32768);
        scale = (scale >>> 10) + 32'sd2097152;
        scale = (scale * h2 + 32'sd8192) >>> 14;
        x = lead * scale;
        sq = ((x >>> 15) * (x >>> 15)) >>> 7;
        x = x - ((sq * h1) >>> 4);
        if (x < 0) x = 0;
        if (x > 32'sd419430400) x = 32'sd419430400;
        return x >>> 12;
    endfunction

    function automatic sample_t compensate(logic [1:0] opc, logic [19:0] raw);
        sample_t s;
        s = '0;
        case (opc)
            esc_pkg::OPC_TEMP:  s.reading = compensate_temp(raw);
            esc_pkg::OPC_PRESS: s = compensate_press(raw);
            esc_pkg::OPC_HUMID: s.reading = compensate_humid(raw);
            default:   s = '0;
        endcase
        return s;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("Mismatch %s at %0t: got %h, expected %h", what, $realtime, got, want);
        error_count++;
    endtask

    // Result checker.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                sample_count++;
                if (pending_samples.size() == 0) begin
                    report_mismatch("unexpected result", m_reading, 32'd0);
                end else begin
                    sample_t want;
                    want = pending_samples.pop_front();
                    if (m_reading !== want.reading)
                        report_mismatch("reading", m_reading, want.reading);
                    if (m_divide_guard !== want.guard)
                        report_mismatch("divide_guard", 32'(m_divide_guard),
                                        32'(want.guard));
                    if (want.guard) guard_count++;
                end
            end
        end
    end

    // Receiver stall and long hold-off, counted in cycles.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (hold_off_cycles > 0) begin
                hold_off_cycles <= hold_off_cycles - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic write_cal(input logic [2:0] idx, input logic [63:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            esc_pkg::CFG_TEMP:       cal_temp     = value[47:0];
            esc_pkg::CFG_PRESS_LOW:  cal_press_lo = value;
            esc_pkg::CFG_PRESS_HIGH: cal_press_hi = value;
            esc_pkg::CFG_MIXED:      cal_mixed    = value[47:0];
            esc_pkg::CFG_HUMID:      cal_humid    = value[39:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    // Sends one request; the prediction is made on acceptance.
    task automatic send_request(input logic [1:0] opc, input logic [19:0] raw);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_opcode      <= opc;
        s_raw_reading <= raw;
        do @(posedge aclk); while (!s_ready);
        pending_samples.push_back(compensate(opc, raw));
        request_count++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    // Typical factory calibration, roughly as found on real parts.
    task automatic load_typical_cal();
        write_cal(esc_pkg::CFG_TEMP, 64'({16'd50, 16'd26435, 16'd27504}));
        write_cal(esc_pkg::CFG_PRESS_LOW, {16'd2855, 16'd3024, 16'hD4BD, 16'd36477});
        write_cal(esc_pkg::CFG_PRESS_HIGH, {16'hC0F4, 16'd15500, 16'hFFF9, 16'd140});
        write_cal(esc_pkg::CFG_MIXED, 64'({8'd0, 16'd360, 8'd75, 16'd6000}));
        write_cal(esc_pkg::CFG_HUMID, 64'({8'd30, 16'd50, 16'd339}));
    endtask

    task automatic load_random_cal();
        write_cal(esc_pkg::CFG_TEMP, {$urandom, $urandom});
        write_cal(esc_pkg::CFG_PRESS_LOW, {$urandom, $urandom});
        write_cal(esc_pkg::CFG_PRESS_HIGH, {$urandom, $urandom});
        write_cal(esc_pkg::CFG_MIXED, {$urandom, $urandom});
        write_cal(esc_pkg::CFG_HUMID, {$urandom, $urandom});
    endtask

    function automatic logic [19:0] plausible_raw(logic [1:0] opc);
        case (opc)
            esc_pkg::OPC_TEMP:  return 20'($urandom_range(400000, 650000));
            esc_pkg::OPC_PRESS: return 20'($urandom_range(250000, 450000));
            default:   return 20'($urandom_range(20000, 40000));
        endcase
    endfunction

    // Zero calibration after reset: pressure divides by zero.
    task automatic test_reset_defaults();
        send_request(esc_pkg::OPC_PRESS, 20'd300000);
        send_request(esc_pkg::OPC_HUMID, 20'hFFFFF);
        send_request(esc_pkg::OPC_TEMP, 20'd0);
        send_request(OPC_UNUSED, 20'hFFFFF);
        wait_drained();
    endtask

    // Directed corners on typical and extreme calibrations.
    task automatic test_directed_corners();
        load_typical_cal();
        send_request(esc_pkg::OPC_PRESS, 20'd400000);
        send_request(esc_pkg::OPC_TEMP, 20'd519888);
        send_request(esc_pkg::OPC_PRESS, 20'd415148);
        send_request(esc_pkg::OPC_HUMID, 20'd30000);
        send_request(esc_pkg::OPC_TEMP, 20'd0);
        send_request(esc_pkg::OPC_PRESS, 20'd0);
        send_request(esc_pkg::OPC_HUMID, 20'd0);
        send_request(esc_pkg::OPC_TEMP, 20'hFFFFF);
        send_request(esc_pkg::OPC_PRESS, 20'hFFFFF);
        send_request(esc_pkg::OPC_HUMID, 20'hFFFFF);
        send_request(OPC_UNUSED, 20'h55555);
        wait_drained();
        write_cal(esc_pkg::CFG_TEMP, 64'hFFFF_FFFF_FFFF_FFFF);
        write_cal(esc_pkg::CFG_PRESS_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_cal(esc_pkg::CFG_PRESS_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_cal(esc_pkg::CFG_MIXED, 64'hFFFF_FFFF_FFFF_FFFF);
        write_cal(esc_pkg::CFG_HUMID, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(esc_pkg::OPC_TEMP, 20'hAAAAA);
        send_request(esc_pkg::OPC_PRESS, 20'h55555);
        send_request(esc_pkg::OPC_HUMID, 20'hAAAAA);
        send_request(esc_pkg::OPC_TEMP, 20'hFFFFF);
        send_request(esc_pkg::OPC_HUMID, 20'h0FFFF);
        wait_drained();
    endtask

    // Mostly plausible measurement cycles on typical and random calibrations under each idling phase.
    task automatic test_measurement_cycles(input int rounds);
        logic [1:0] opc;
        for (int i = 0; i < rounds; i++) begin
            case (i % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            if (i % 3 == 2) load_random_cal();
            else load_typical_cal();
            for (int k = 0; k < 52; k++) begin
                if ($urandom_range(9) < 8) begin
                    send_request(esc_pkg::OPC_TEMP, plausible_raw(esc_pkg::OPC_TEMP));
                    send_request(esc_pkg::OPC_PRESS, plausible_raw(esc_pkg::OPC_PRESS));
                    send_request(esc_pkg::OPC_HUMID, plausible_raw(esc_pkg::OPC_HUMID));
                end else begin
                    opc = 2'($urandom_range(3));
                    send_request(opc, 20'($urandom));
                end
            end
            wait_drained();
        end
    endtask

    // Long receiver hold-off while requests keep coming.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 2000;
        for (int k = 0; k < 6; k++)
            send_request(2'($urandom_range(2)), 20'($urandom));
        wait_drained();
    endtask

    initial begin
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_opcode        = esc_pkg::OPC_TEMP;
        s_raw_reading   = '0;
        m_ready         = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = esc_pkg::CFG_TEMP;
        cfg_wdata       = '0;
        cal_temp        = '0;
        cal_press_lo    = '0;
        cal_press_hi    = '0;
        cal_mixed       = '0;
        cal_humid       = '0;
        fine_temp       = '0;
        error_count     = 0;
        sample_count    = 0;
        request_count   = 0;
        guard_count     = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_directed_corners();
        test_backpressure();
        test_measurement_cycles(5);

        $display("Covered %0d requests and %0d results, %0d with a zero divisor,",
                 request_count, sample_count, guard_count);
        $display("over typical, extreme and random calibrations with varied idling.");
        if (error_count == 0 && pending_samples.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- env_sensor_compensation.f -----
src/esc_pkg.sv
src/esc_alu.sv
src/env_sensor_compensation.sv
verif/env_sensor_compensation_tb.sv
